/* rtl/demand_paging_lru_translator_core_macros.svh */
`ifndef DEMAND_PAGING_LRU_TRANSLATOR_CORE_MACROS_SVH
`define DEMAND_PAGING_LRU_TRANSLATOR_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define DPTL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DPTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dptl_pkg.sv */
`default_nettype none

package dptl_pkg;

  // fixed field geometry
  localparam int unsigned VADDR_BITS     = 22;
  localparam int unsigned OFFSET_BITS    = 12;
  localparam int unsigned PAGE_BITS      = VADDR_BITS - OFFSET_BITS;
  localparam int unsigned PADDR_BITS     = 16;
  localparam int unsigned FRAME_OUT_BITS = PADDR_BITS - OFFSET_BITS;

  // defaults for the top-level parameters
  localparam int unsigned DEF_FRAME_COUNT = 16;
  localparam int unsigned DEF_STAMP_BITS  = 32;

  // access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SEARCH,
    ST_EVICT
  } state_e;

  // update command for one frame cell
  typedef struct packed {
    logic sel;       // this cell is written this cycle
    logic fill;      // new owner page is loaded, else only touched
    logic is_write;  // access kind of the item
  } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/demand_paging_lru_translator_core.sv */
// channel | handshake              | payload
// --------+------------------------+-------------------------------------------
// in      | in_valid_i / in_ready_o| command_i, virtual_address_i
// out     | out_valid_o/out_ready_i| physical_address_o, page_fault_o,
//         |                        | frame_used_o, evicted_o, victim_page_o,
//         |                        | write_back_o
//
// a hit or a load into a free frame registers its result from the lookup state
// once the result register is free; no new input is taken until then
// a replacement walks the victim token down the row of FRAME_COUNT cells in the
// search state; the result registers in the evict state once the register is free
// reset invalidates every frame cell and clears fill count and access stamp
// a stalled output holds the result register; the next input is taken
// meanwhile and waits in lookup until the register frees up
`default_nettype none

module demand_paging_lru_translator_core #(
  parameter int unsigned FRAME_COUNT = dptl_pkg::DEF_FRAME_COUNT,
  parameter int unsigned STAMP_BITS  = dptl_pkg::DEF_STAMP_BITS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                command_i,
  input  wire logic [dptl_pkg::VADDR_BITS-1:0]     virtual_address_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [dptl_pkg::PADDR_BITS-1:0]          physical_address_o,
  output logic                                     page_fault_o,
  output logic [dptl_pkg::FRAME_OUT_BITS-1:0]      frame_used_o,
  output logic                                     evicted_o,
  output logic [dptl_pkg::PAGE_BITS-1:0]           victim_page_o,
  output logic                                     write_back_o
);
  import dptl_pkg::*;

  `include "demand_paging_lru_translator_core_macros.svh"

  localparam int unsigned FRAME_BITS  = $clog2(FRAME_COUNT);
  localparam int unsigned IN_USE_BITS = $clog2(FRAME_COUNT + 1);
  localparam logic [FRAME_BITS-1:0]  CNT_LAST   = FRAME_BITS'(FRAME_COUNT - 1);
  localparam logic [IN_USE_BITS-1:0] FRAMES_ALL = IN_USE_BITS'(FRAME_COUNT);

  state_e                   state_q, state_d;
  logic [FRAME_BITS-1:0]    cnt_q, cnt_d;
  logic [IN_USE_BITS-1:0]   in_use_q;
  logic [STAMP_BITS-1:0]    stamp_q;
  logic                     cmd_q;
  logic [PAGE_BITS-1:0]     page_q;
  logic [OFFSET_BITS-1:0]   offset_q;

  logic                     in_xfer;
  logic                     out_free;
  logic                     commit;
  logic                     fill;
  logic [FRAME_BITS-1:0]    target;
  logic                     has_free;

  logic [FRAME_COUNT-1:0]   hits;
  logic                     hit_any;
  logic [FRAME_BITS-1:0]    hit_idx;
  cell_cmd_t                cell_cmd [FRAME_COUNT];

  logic                     tok_vld   [FRAME_COUNT+1];
  logic [STAMP_BITS-1:0]    tok_age   [FRAME_COUNT+1];
  logic [PAGE_BITS-1:0]     tok_owner [FRAME_COUNT+1];
  logic                     tok_dirty [FRAME_COUNT+1];
  logic [FRAME_BITS-1:0]    tok_idx   [FRAME_COUNT+1];

  logic                     out_valid_q;
  logic [PADDR_BITS-1:0]    paddr_q;
  logic                     fault_q;
  logic [FRAME_OUT_BITS-1:0] frame_q;
  logic                     evicted_q;
  logic [PAGE_BITS-1:0]     victim_q;
  logic                     wback_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign has_free   = (in_use_q < FRAMES_ALL);

  // empty token enters the head of the row
  assign tok_vld[0]   = 1'b0;
  assign tok_age[0]   = '0;
  assign tok_owner[0] = '0;
  assign tok_dirty[0] = 1'b0;
  assign tok_idx[0]   = '0;

  // row of frame cells
  for (genvar k = 0; k < FRAME_COUNT; k++) begin : g_cell
    assign cell_cmd[k] = '{sel:      commit && (target == FRAME_BITS'(k)),
                           fill:     fill,
                           is_write: cmd_q};

    dptl_cell #(
      .FRAME_COUNT(FRAME_COUNT),
      .STAMP_BITS (STAMP_BITS),
      .CELL_INDEX (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cell_cmd[k]),
      .page_i     (page_q),
      .stamp_i    (stamp_q),
      .hit_o      (hits[k]),
      .tok_vld_i  (tok_vld[k]),
      .tok_age_i  (tok_age[k]),
      .tok_owner_i(tok_owner[k]),
      .tok_dirty_i(tok_dirty[k]),
      .tok_idx_i  (tok_idx[k]),
      .tok_vld_o  (tok_vld[k+1]),
      .tok_age_o  (tok_age[k+1]),
      .tok_owner_o(tok_owner[k+1]),
      .tok_dirty_o(tok_dirty[k+1]),
      .tok_idx_o  (tok_idx[k+1])
    );
  end

  // one-hot hit vector to frame number
  always_comb begin
    hit_idx = '0;
    for (int k = 0; k < FRAME_COUNT; k++) begin
      if (hits[k]) begin
        hit_idx = hit_idx | FRAME_BITS'(k);
      end
    end
  end
  assign hit_any = |hits;

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    commit  = 1'b0;
    fill    = 1'b0;
    target  = hit_idx;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!hit_any && !has_free) begin
          state_d = ST_SEARCH;
          cnt_d   = CNT_LAST;
        end else begin
          if (!hit_any) begin
            fill   = 1'b1;
            target = FRAME_BITS'(in_use_q);
          end
          if (out_free) begin
            commit  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_SEARCH: begin
        if (cnt_q == '0) begin
          state_d = ST_EVICT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_EVICT: begin
        fill   = 1'b1;
        target = tok_idx[FRAME_COUNT];
        if (out_free) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // fill count and access stamp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      stamp_q  <= '0;
    end else begin
      if (in_xfer) begin
        stamp_q <= stamp_q + 1'b1;
      end
      if (commit && fill && (state_q == ST_LOOKUP)) begin
        in_use_q <= in_use_q + 1'b1;
      end
    end
  end

  // input item capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q    <= command_i;
      page_q   <= virtual_address_i[VADDR_BITS-1:OFFSET_BITS];
      offset_q <= virtual_address_i[OFFSET_BITS-1:0];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      paddr_q   <= {FRAME_OUT_BITS'(target), offset_q};
      fault_q   <= fill;
      frame_q   <= FRAME_OUT_BITS'(target);
      evicted_q <= (state_q == ST_EVICT);
      victim_q  <= (state_q == ST_EVICT) ? tok_owner[FRAME_COUNT] : '0;
      wback_q   <= (state_q == ST_EVICT) && tok_dirty[FRAME_COUNT];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign physical_address_o = paddr_q;
  assign page_fault_o       = fault_q;
  assign frame_used_o       = frame_q;
  assign evicted_o          = evicted_q;
  assign victim_page_o      = victim_q;
  assign write_back_o       = wback_q;

  // checks
  `DPTL_ASSERT_NOW(a_hit_unique, state_q == ST_LOOKUP, $onehot0(hits), "page held by two frames")
  `DPTL_ASSERT_NOW(a_evict_full, out_valid_o && evicted_o, in_use_q == FRAMES_ALL, "eviction with free frames")
  `DPTL_ASSERT_NOW(a_token_ready, state_q == ST_EVICT, tok_vld[FRAME_COUNT], "no victim at row end")
  `DPTL_ASSERT_NEXT(a_stamp_hold, !in_xfer, $stable(stamp_q), "stamp moved without transfer")

endmodule

`default_nettype wire

/* rtl/dptl_cell.sv */
`default_nettype none

module dptl_cell #(
  parameter int unsigned FRAME_COUNT = dptl_pkg::DEF_FRAME_COUNT,
  parameter int unsigned STAMP_BITS  = dptl_pkg::DEF_STAMP_BITS,
  parameter int unsigned CELL_INDEX  = 0
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire dptl_pkg::cell_cmd_t              cmd_i,
  input  wire logic [dptl_pkg::PAGE_BITS-1:0]   page_i,
  input  wire logic [STAMP_BITS-1:0]            stamp_i,
  output logic                                  hit_o,
  input  wire logic                             tok_vld_i,
  input  wire logic [STAMP_BITS-1:0]            tok_age_i,
  input  wire logic [dptl_pkg::PAGE_BITS-1:0]   tok_owner_i,
  input  wire logic                             tok_dirty_i,
  input  wire logic [$clog2(FRAME_COUNT)-1:0]   tok_idx_i,
  output logic                                  tok_vld_o,
  output logic [STAMP_BITS-1:0]                 tok_age_o,
  output logic [dptl_pkg::PAGE_BITS-1:0]        tok_owner_o,
  output logic                                  tok_dirty_o,
  output logic [$clog2(FRAME_COUNT)-1:0]        tok_idx_o
);
  import dptl_pkg::*;

  localparam int unsigned FRAME_BITS = $clog2(FRAME_COUNT);

  logic                  valid_q;
  logic [PAGE_BITS-1:0]  owner_q;
  logic [STAMP_BITS-1:0] age_q;
  logic                  dirty_q;
  logic                  own_better;

  // frame state: valid is control, the rest payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.sel && cmd_i.fill) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel) begin
      age_q <= stamp_i;
      if (cmd_i.fill) begin
        owner_q <= page_i;
        dirty_q <= (cmd_i.is_write == CMD_WRITE);
      end else begin
        dirty_q <= dirty_q | (cmd_i.is_write == CMD_WRITE);
      end
    end
  end

  // page match against the owner
  assign hit_o = valid_q && (owner_q == page_i);

  // oldest-so-far compare, ties go to the lower owner page
  assign own_better = valid_q && (!tok_vld_i || (age_q < tok_age_i) ||
                      ((age_q == tok_age_i) && (owner_q < tok_owner_i)));

  // victim token handed to the next cell every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_o <= 1'b0;
    end else begin
      tok_vld_o <= valid_q | tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (own_better) begin
      tok_age_o   <= age_q;
      tok_owner_o <= owner_q;
      tok_dirty_o <= dirty_q;
      tok_idx_o   <= FRAME_BITS'(CELL_INDEX);
    end else begin
      tok_age_o   <= tok_age_i;
      tok_owner_o <= tok_owner_i;
      tok_dirty_o <= tok_dirty_i;
      tok_idx_o   <= tok_idx_i;
    end
  end

endmodule

`default_nettype wire

/* verif/demand_paging_lru_translator_core_tb.sv */
`default_nettype none

module demand_paging_lru_translator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dptl_pkg::*;

  // block geometry at its defaults
  localparam int unsigned STAMP_W = DEF_STAMP_BITS;
  localparam int unsigned FRAMES = DEF_FRAME_COUNT;
  localparam int unsigned PAGES = 1 << PAGE_BITS;
  localparam int unsigned ITEM_COUNT = 1900;
  localparam int unsigned DRAIN_CYCLES = 2 * FRAMES + 8;

  typedef struct packed {
    logic [PADDR_BITS-1:0] paddr;
    logic fault;
    logic [FRAME_OUT_BITS-1:0] frame;
    logic evicted;
    logic [PAGE_BITS-1:0] victim;
    logic wb;
  } xlat_result_t;

  // translation predictor and queue of expected translations
  class xlat_scoreboard;
    bit present[PAGES];
    bit dirty[PAGES];
    logic [FRAME_OUT_BITS-1:0] frame_of[PAGES];
    logic [PAGE_BITS-1:0] owner[FRAMES];
    logic [STAMP_W-1:0] age[FRAMES];
    int unsigned fill;
    logic [STAMP_W-1:0] stamp;
    xlat_result_t expected_xlat[$];
    int unsigned errors;
    int unsigned results_checked;

    function new();
      foreach (present[i]) begin
        present[i] = 1'b0;
        dirty[i] = 1'b0;
      end
      fill = 0;
      stamp = '0;
      errors = 0;
      results_checked = 0;
    endfunction

    task report_mismatch(input string what, input longint unsigned got,
                         input longint unsigned want);
      $display("mismatch at result %0d, %s: got 0x%0h, want 0x%0h",
               results_checked, what, got, want);
      errors++;
    endtask

    // work out the translation of one accepted access
    function void note_access(input logic cmd, input logic [VADDR_BITS-1:0] va);
      xlat_result_t r;
      logic [PAGE_BITS-1:0] pg;
      logic [FRAME_OUT_BITS-1:0] fr;
      int unsigned best;
      pg = va[VADDR_BITS-1:OFFSET_BITS];
      r = '0;
      stamp = stamp + 1'b1;
      if (present[pg]) begin
        fr = frame_of[pg];
      end else begin
        r.fault = 1'b1;
        if (fill < FRAMES) begin
          fr = FRAME_OUT_BITS'(fill);
          fill++;
        end else begin
          // oldest stamp wins, ties go to the lowest owner page
          best = 0;
          for (int unsigned f = 1; f < FRAMES; f++) begin
            if (age[f] < age[best] || (age[f] == age[best] && owner[f] < owner[best]))
              best = f;
          end
          fr = FRAME_OUT_BITS'(best);
          r.evicted = 1'b1;
          r.victim = owner[best];
          r.wb = dirty[owner[best]];
          dirty[owner[best]] = 1'b0;
          present[owner[best]] = 1'b0;
        end
        frame_of[pg] = fr;
        owner[fr] = pg;
        present[pg] = 1'b1;
        dirty[pg] = 1'b0;
      end
      age[fr] = stamp;
      if (cmd == CMD_WRITE) dirty[pg] = 1'b1;
      r.frame = fr;
      r.paddr = {fr, va[OFFSET_BITS-1:0]};
      expected_xlat.push_back(r);
    endfunction

    task check_result(input xlat_result_t got);
      xlat_result_t want;
      if (expected_xlat.size() == 0) begin
        report_mismatch("unexpected transfer", got, 0);
      end else begin
        want = expected_xlat.pop_front();
        if (got.paddr !== want.paddr) report_mismatch("physical_address", got.paddr, want.paddr);
        if (got.fault !== want.fault) report_mismatch("page_fault", got.fault, want.fault);
        if (got.frame !== want.frame) report_mismatch("frame_used", got.frame, want.frame);
        if (got.evicted !== want.evicted) report_mismatch("evicted", got.evicted, want.evicted);
        if (got.victim !== want.victim) report_mismatch("victim_page", got.victim, want.victim);
        if (got.wb !== want.wb) report_mismatch("write_back", got.wb, want.wb);
      end
      results_checked++;
    endtask

    function int unsigned pending();
      return expected_xlat.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic command_i;
  logic [VADDR_BITS-1:0] virtual_address_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [PADDR_BITS-1:0] physical_address_o;
  logic page_fault_o;
  logic [FRAME_OUT_BITS-1:0] frame_used_o;
  logic evicted_o;
  logic [PAGE_BITS-1:0] victim_page_o;
  logic write_back_o;

  xlat_scoreboard sb;
  int unsigned results_seen;
  bit tx_calm;

  demand_paging_lru_translator_core #(
    .FRAME_COUNT(FRAMES),
    .STAMP_BITS(STAMP_W)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .command_i(command_i),
    .virtual_address_i(virtual_address_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .physical_address_o(physical_address_o),
    .page_fault_o(page_fault_o),
    .frame_used_o(frame_used_o),
    .evicted_o(evicted_o),
    .victim_page_o(victim_page_o),
    .write_back_o(write_back_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_result({physical_address_o, page_fault_o, frame_used_o, evicted_o,
                         victim_page_o, write_back_o});
        results_seen++;
      end
      if (in_valid_i && in_ready_o) sb.note_access(command_i, virtual_address_i);
    end
  end

  // offer one access and wait for its transfer
  task automatic send_access(input logic cmd, input logic [VADDR_BITS-1:0] va);
    int unsigned gap;
    gap = tx_calm ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    command_i = cmd;
    virtual_address_i = va;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // fill every frame, then force clean and dirty replacements
  task automatic run_directed();
    send_access(CMD_READ, 22'h000000);
    send_access(CMD_WRITE, 22'h3FFFFF);
    send_access(CMD_READ, 22'h3FF000);
    for (int unsigned p = 2; p < FRAMES; p++)
      send_access(p[0] ? CMD_WRITE : CMD_READ, {PAGE_BITS'(p), 12'(p * 257)});
    send_access(CMD_READ, {PAGE_BITS'(16), 12'hFFF});
    send_access(CMD_WRITE, {PAGE_BITS'(17), 12'h000});
    send_access(CMD_READ, 22'h000ABC);
    send_access(CMD_READ, {PAGE_BITS'(18), 12'h123});
  endtask

  // phases over random page pools: hot sets, thrashing sets and noise
  task automatic run_random(input int unsigned total);
    int unsigned sent;
    int unsigned span;
    int unsigned pool_size;
    logic [PAGE_BITS-1:0] pool[$];
    logic [PAGE_BITS-1:0] pg;
    logic cmd;
    sent = 0;
    while (sent < total) begin
      pool.delete();
      case ($urandom_range(0, 2))
        0: pool_size = $urandom_range(4, FRAMES);
        1: pool_size = $urandom_range(FRAMES + 1, FRAMES + 8);
        default: pool_size = $urandom_range(FRAMES + 9, 64);
      endcase
      repeat (pool_size) pool.push_back(PAGE_BITS'($urandom));
      tx_calm = ($urandom_range(0, 3) == 0);
      span = $urandom_range(40, 160);
      repeat (span) begin
        if (sent < total) begin
          cmd = ($urandom_range(0, 9) < 4) ? CMD_WRITE : CMD_READ;
          if ($urandom_range(0, 9) == 0) pg = PAGE_BITS'($urandom);
          else pg = pool[$urandom_range(0, pool_size - 1)];
          send_access(cmd, {pg, OFFSET_BITS'($urandom)});
          sent++;
        end
      end
    end
  endtask

  // result side: random stalls, calm stretches and a few long hold-offs
  initial begin
    int unsigned gap;
    int unsigned hold;
    int unsigned next_hold;
    int unsigned mode_left;
    bit rx_calm;
    gap = 0;
    hold = 0;
    next_hold = 500;
    mode_left = 0;
    rx_calm = 1'b0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        rx_calm = ($urandom_range(0, 2) == 0);
        mode_left = 150;
      end
      mode_left--;
      if (results_seen >= next_hold) begin
        hold = 250;
        next_hold += 700;
      end
      if (hold > 0) begin
        out_ready_i = 1'b0;
        hold--;
      end else if (gap > 0) begin
        out_ready_i = 1'b0;
        gap--;
      end else begin
        out_ready_i = 1'b1;
        if (!rx_calm) gap = pick_gap();
      end
    end
  end

  // reset, stimulus, drain and verdict
  initial begin
    sb = new();
    results_seen = 0;
    tx_calm = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = CMD_READ;
    virtual_address_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    run_directed();
    run_random(ITEM_COUNT - 21);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/dptl_pkg.sv
rtl/dptl_cell.sv
rtl/demand_paging_lru_translator_core.sv
verif/demand_paging_lru_translator_core_tb.sv
